>>> sv/shac_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 compression package
// Shared widths, codes, round constants, sigma functions and the command
// bundle that the controller sends to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package shac_pkg;

   localparam int WORD_WIDTH        = 32;
   localparam int INDEX_WIDTH       = 4;
   localparam int HASH_INDEX_WIDTH  = 3;
   localparam int ROUND_WIDTH       = 6;
   localparam int HASH_WORDS        = 8;
   localparam int BLOCK_WORDS       = 16;
   localparam int ROUNDS            = 64;

   localparam logic                        OP_LOAD_CHAIN    = 1'b0;
   localparam logic                        OP_WRITE_BLOCK   = 1'b1;
   localparam logic [INDEX_WIDTH-1:0]      LAST_BLOCK_INDEX = 4'd15;
   localparam logic [ROUND_WIDTH-1:0]      LAST_ROUND       = 6'd63;
   localparam logic [HASH_INDEX_WIDTH-1:0] LAST_HASH_INDEX  = 3'd7;

   localparam logic [WORD_WIDTH-1:0] ROUND_K [ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FINISH,
      ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic                        write_chain;
      logic                        write_block;
      logic                        start;
      logic                        round;
      logic [ROUND_WIDTH-1:0]      round_idx;
      logic                        finish;
      logic [HASH_INDEX_WIDTH-1:0] out_idx;
   } cmd_type;

   function automatic logic [WORD_WIDTH-1:0] big_sigma0(input logic [WORD_WIDTH-1:0] x);
      big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [WORD_WIDTH-1:0] big_sigma1(input logic [WORD_WIDTH-1:0] x);
      big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [WORD_WIDTH-1:0] small_sigma0(input logic [WORD_WIDTH-1:0] x);
      small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [WORD_WIDTH-1:0] small_sigma1(input logic [WORD_WIDTH-1:0] x);
      small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

endpackage

`default_nettype wire

>>> sv/shac_req_if.sv
// ----------------------------------------------------------------------------
// SHA-256 compression request channel
// Valid/ready channel that carries chaining-word loads and message words.
// ----------------------------------------------------------------------------
`default_nettype none

interface shac_req_if;
   import shac_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   operation;
   logic [INDEX_WIDTH-1:0] word_index;
   logic [WORD_WIDTH-1:0]  word_value;

   modport source (output valid, output operation, output word_index, output word_value,
                   input ready);
   modport sink   (input valid, input operation, input word_index, input word_value,
                   output ready);
endinterface

`default_nettype wire

>>> sv/shac_rsp_if.sv
// ----------------------------------------------------------------------------
// SHA-256 compression response channel
// Valid/ready channel that carries the updated chaining words.
// ----------------------------------------------------------------------------
`default_nettype none

interface shac_rsp_if;
   import shac_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [WORD_WIDTH-1:0]       hash_word;
   logic [HASH_INDEX_WIDTH-1:0] hash_index;
   logic                        last;

   modport source (output valid, output hash_word, output hash_index, output last,
                   input ready);
   modport sink   (input valid, input hash_word, input hash_index, input last,
                   output ready);
endinterface

`default_nettype wire

>>> sv/shac_ctrl.sv
// ----------------------------------------------------------------------------
// SHA-256 compression controller
// Sequences word stores, the 64 rounds, the final addition and the output
// of the eight chaining words.
// ----------------------------------------------------------------------------
`default_nettype none

module shac_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_operation,
   input  logic [shac_pkg::INDEX_WIDTH-1:0]   req_word_index,
   output logic                               req_ready,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output shac_pkg::cmd_type                  cmd
);
   import shac_pkg::*;

   state_type                   state_ff, state_in;
   logic [ROUND_WIDTH-1:0]      round_ff, round_in;
   logic [HASH_INDEX_WIDTH-1:0] out_ff, out_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         round_ff <= '0;
         out_ff   <= '0;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
         out_ff   <= out_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      round_in      = round_ff;
      out_in        = out_ff;
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;
      cmd           = '0;
      cmd.round_idx = round_ff;
      cmd.out_idx   = out_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_operation == OP_LOAD_CHAIN) begin
                  cmd.write_chain = ~req_word_index[INDEX_WIDTH-1];
               end else begin
                  cmd.write_block = 1'b1;
                  if (req_word_index == LAST_BLOCK_INDEX) begin
                     cmd.start = 1'b1;
                     round_in  = '0;
                     state_in  = ST_ROUND;
                  end
               end
            end
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            round_in  = round_ff + 1'b1;
            if (round_ff == LAST_ROUND) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            out_in     = '0;
            state_in   = ST_OUTPUT;
         end
         ST_OUTPUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               out_in = out_ff + 1'b1;
               if (out_ff == LAST_HASH_INDEX) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> sv/shac_dp.sv
// ----------------------------------------------------------------------------
// SHA-256 compression datapath
// Holds the chaining value, the message block, the sixteen-word schedule
// window and the working variables, and computes one round per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module shac_dp (
   input  logic                                  clock,
   input  shac_pkg::cmd_type                     cmd,
   input  logic [shac_pkg::INDEX_WIDTH-1:0]      word_index,
   input  logic [shac_pkg::WORD_WIDTH-1:0]       word_value,
   output logic [shac_pkg::WORD_WIDTH-1:0]       hash_word,
   output logic [shac_pkg::HASH_INDEX_WIDTH-1:0] hash_index,
   output logic                                  last
);
   import shac_pkg::*;

   logic [WORD_WIDTH-1:0] chain_ff [HASH_WORDS];
   logic [WORD_WIDTH-1:0] chain_in [HASH_WORDS];
   logic [WORD_WIDTH-1:0] block_ff [BLOCK_WORDS];
   logic [WORD_WIDTH-1:0] block_in [BLOCK_WORDS];
   logic [WORD_WIDTH-1:0] sched_ff [BLOCK_WORDS];
   logic [WORD_WIDTH-1:0] sched_in [BLOCK_WORDS];
   logic [WORD_WIDTH-1:0] work_ff  [HASH_WORDS];
   logic [WORD_WIDTH-1:0] work_in  [HASH_WORDS];

   logic [WORD_WIDTH-1:0] choose;
   logic [WORD_WIDTH-1:0] majority;
   logic [WORD_WIDTH-1:0] temp1;
   logic [WORD_WIDTH-1:0] temp2;
   logic [WORD_WIDTH-1:0] sched_next;

   always_ff @(posedge clock) begin
      chain_ff <= chain_in;
      block_ff <= block_in;
      sched_ff <= sched_in;
      work_ff  <= work_in;
   end

   assign choose     = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
   assign majority   = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2]) ^
                       (work_ff[1] & work_ff[2]);
   assign temp1      = work_ff[7] + big_sigma1(work_ff[4]) + choose +
                       ROUND_K[cmd.round_idx] + sched_ff[0];
   assign temp2      = big_sigma0(work_ff[0]) + majority;
   assign sched_next = small_sigma1(sched_ff[14]) + sched_ff[9] +
                       small_sigma0(sched_ff[1]) + sched_ff[0];

   always_comb begin
      chain_in = chain_ff;
      block_in = block_ff;
      sched_in = sched_ff;
      work_in  = work_ff;
      if (cmd.write_chain) begin
         chain_in[word_index[HASH_INDEX_WIDTH-1:0]] = word_value;
      end
      if (cmd.write_block) begin
         block_in[word_index] = word_value;
      end
      if (cmd.start) begin
         for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
            sched_in[i] = block_ff[i];
         end
         sched_in[BLOCK_WORDS-1] = word_value;
         work_in = chain_ff;
      end
      if (cmd.round) begin
         for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
            sched_in[i] = sched_ff[i+1];
         end
         sched_in[BLOCK_WORDS-1] = sched_next;
         work_in[7] = work_ff[6];
         work_in[6] = work_ff[5];
         work_in[5] = work_ff[4];
         work_in[4] = work_ff[3] + temp1;
         work_in[3] = work_ff[2];
         work_in[2] = work_ff[1];
         work_in[1] = work_ff[0];
         work_in[0] = temp1 + temp2;
      end
      if (cmd.finish) begin
         for (int i = 0; i < HASH_WORDS; i++) begin
            chain_in[i] = chain_ff[i] + work_ff[i];
         end
      end
   end

   assign hash_word  = chain_ff[cmd.out_idx];
   assign hash_index = cmd.out_idx;
   assign last       = (cmd.out_idx == LAST_HASH_INDEX);

endmodule

`default_nettype wire

>>> sv/sha256_block_compress.sv
// ----------------------------------------------------------------------------
// SHA-256 block compression
// Stores chaining and message words, compresses one 512-bit block when
// message word 15 arrives and returns the eight updated chaining words.
// ----------------------------------------------------------------------------
//
//   Channel    Direction   Payload                               Handshake
//   req_chan   in          operation, word_index, word_value     valid/ready
//   rsp_chan   out         hash_word, hash_index, last           valid/ready
//
// Message word 15 starts the 64 rounds, the final addition and then eight output
// transactions, so the next request is accepted only after the last output
// word has been taken.
// Reset returns the controller to idle; stored words are undefined until written.
// While rsp_chan.ready is low the current output word holds.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_block_compress (
   input  logic       clock,
   input  logic       reset,
   shac_req_if.sink   req_chan,
   shac_rsp_if.source rsp_chan
);
   import shac_pkg::*;

   cmd_type cmd;

   shac_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_chan.valid),
      .req_operation  (req_chan.operation),
      .req_word_index (req_chan.word_index),
      .req_ready      (req_chan.ready),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .cmd            (cmd)
   );

   shac_dp u_dp (
      .clock      (clock),
      .cmd        (cmd),
      .word_index (req_chan.word_index),
      .word_value (req_chan.word_value),
      .hash_word  (rsp_chan.hash_word),
      .hash_index (rsp_chan.hash_index),
      .last       (rsp_chan.last)
   );

endmodule

`default_nettype wire

>>> bench/tb_sha256_block_compress.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-256 block compression testbench
// Loads chaining words and message words into the block, predicts every
// compression with a local SHA-256 round model and checks each returned
// chaining word against it. Both channels idle at random, and one long
// receiver stall forces the block to back up and hold off its input.
// ----------------------------------------------------------------------------

module tb_sha256_block_compress;
   import shac_pkg::*;

   localparam int          MAX_IDLE     = 13;
   localparam int          HOLD_CYCLES  = 400;
   localparam int          RANDOM_ITEMS = 120;
   localparam int          DRAIN_CYCLES = 100;
   localparam int unsigned TIMEOUT_NS   = 2_000_000;

   typedef struct packed {
      logic [WORD_WIDTH-1:0]       hash_word;
      logic [HASH_INDEX_WIDTH-1:0] hash_index;
      logic                        last;
   } hash_result_type;

   logic clock;
   logic reset;

   shac_req_if req_if ();
   shac_rsp_if rsp_if ();

   sha256_block_compress uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   logic [WORD_WIDTH-1:0] chain_model [HASH_WORDS];
   logic [WORD_WIDTH-1:0] block_model [BLOCK_WORDS];
   hash_result_type       expected_hashes [$];
   int                    errors = 0;
   bit                    idle_on = 1'b1;
   bit                    hold_request = 1'b0;
   bit                    rsp_taken = 1'b0;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic logic [WORD_WIDTH-1:0] rotr(input logic [WORD_WIDTH-1:0] x,
                                                  input int n);
      return (x >> n) | (x << (WORD_WIDTH - n));
   endfunction

   function automatic void compress_into_chain();
      logic [WORD_WIDTH-1:0] sched [ROUNDS];
      logic [WORD_WIDTH-1:0] v [HASH_WORDS];
      logic [WORD_WIDTH-1:0] lo0, lo1, sum1, sum2;
      hash_result_type       result;
      for (int t = 0; t < BLOCK_WORDS; t++) begin
         sched[t] = block_model[t];
      end
      for (int t = BLOCK_WORDS; t < ROUNDS; t++) begin
         lo0 = rotr(sched[t-15], 7) ^ rotr(sched[t-15], 18) ^ (sched[t-15] >> 3);
         lo1 = rotr(sched[t-2], 17) ^ rotr(sched[t-2], 19) ^ (sched[t-2] >> 10);
         sched[t] = lo1 + sched[t-7] + lo0 + sched[t-16];
      end
      for (int i = 0; i < HASH_WORDS; i++) begin
         v[i] = chain_model[i];
      end
      for (int t = 0; t < ROUNDS; t++) begin
         sum1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
              + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + sched[t];
         sum2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
              + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6];
         v[6] = v[5];
         v[5] = v[4];
         v[4] = v[3] + sum1;
         v[3] = v[2];
         v[2] = v[1];
         v[1] = v[0];
         v[0] = sum1 + sum2;
      end
      for (int i = 0; i < HASH_WORDS; i++) begin
         chain_model[i]    = chain_model[i] + v[i];
         result.hash_word  = chain_model[i];
         result.hash_index = HASH_INDEX_WIDTH'(i);
         result.last       = (HASH_INDEX_WIDTH'(i) == LAST_HASH_INDEX);
         expected_hashes.push_back(result);
      end
   endfunction

   function automatic void apply_word(input logic op, input logic [INDEX_WIDTH-1:0] idx,
                                      input logic [WORD_WIDTH-1:0] value);
      if (op == OP_LOAD_CHAIN) begin
         if (idx < HASH_WORDS) begin
            chain_model[idx[HASH_INDEX_WIDTH-1:0]] = value;
         end
      end else begin
         block_model[idx] = value;
         if (idx == LAST_BLOCK_INDEX) begin
            compress_into_chain();
         end
      end
   endfunction

   function automatic logic [WORD_WIDTH-1:0] random_word();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_word(input logic op, input logic [INDEX_WIDTH-1:0] idx,
                            input logic [WORD_WIDTH-1:0] value);
      int gap;
      gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap > 0) begin
         req_if.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid      = 1'b1;
      req_if.operation  = op;
      req_if.word_index = idx;
      req_if.word_value = value;
      do @(posedge clock); while (!req_if.ready);
      apply_word(op, idx, value);
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      hash_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         rsp_taken = 1'b1;
         if (expected_hashes.size() == 0) begin
            $display("%0t: unexpected transaction, hash_word %h hash_index %0d last %b",
                     $time, rsp_if.hash_word, rsp_if.hash_index, rsp_if.last);
            errors++;
         end else begin
            want = expected_hashes.pop_front();
            if (rsp_if.hash_word !== want.hash_word) begin
               $display("%0t: hash_word mismatch, expected %h, actual %h",
                        $time, want.hash_word, rsp_if.hash_word);
               errors++;
            end
            if (rsp_if.hash_index !== want.hash_index) begin
               $display("%0t: hash_index mismatch, expected %0d, actual %0d",
                        $time, want.hash_index, rsp_if.hash_index);
               errors++;
            end
            if (rsp_if.last !== want.last) begin
               $display("%0t: last mismatch, expected %b, actual %b",
                        $time, want.last, rsp_if.last);
               errors++;
            end
         end
      end
   end

   // The receiver stalls a random number of cycles after each transaction, or a
   // long fixed stretch when a hold is requested.
   initial begin
      int stall_left;
      stall_left   = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            stall_left   = HOLD_CYCLES;
            hold_request = 1'b0;
         end else if (rsp_taken) begin
            stall_left = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
         end
         rsp_taken = 1'b0;
         if (stall_left > 0) begin
            rsp_if.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_if.ready = 1'b1;
         end
      end
   end

   task automatic test_chain_load();
      logic [WORD_WIDTH-1:0] initial_hash [HASH_WORDS];
      initial_hash = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                       32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      for (int i = 0; i < HASH_WORDS; i++) begin
         send_word(OP_LOAD_CHAIN, INDEX_WIDTH'(i), initial_hash[i]);
      end
      send_word(OP_LOAD_CHAIN, INDEX_WIDTH'(HASH_WORDS), '1);
      send_word(OP_LOAD_CHAIN, LAST_BLOCK_INDEX, '0);
   endtask

   task automatic test_abc_block();
      send_word(OP_WRITE_BLOCK, 4'd0, 32'h61626380);
      for (int i = 1; i < BLOCK_WORDS - 1; i++) begin
         send_word(OP_WRITE_BLOCK, INDEX_WIDTH'(i), '0);
      end
      send_word(OP_WRITE_BLOCK, LAST_BLOCK_INDEX, 32'h00000018);
   endtask

   // A long receiver stall with back-to-back requests lets the output back up
   // until the block stops accepting input.
   task automatic test_back_pressure();
      hold_request = 1'b1;
      idle_on      = 1'b0;
      send_word(OP_WRITE_BLOCK, 4'd0, '1);
      send_word(OP_WRITE_BLOCK, LAST_BLOCK_INDEX, '1);
      send_word(OP_WRITE_BLOCK, LAST_BLOCK_INDEX, '0);
      send_word(OP_LOAD_CHAIN, 4'd3, $urandom);
      send_word(OP_WRITE_BLOCK, LAST_BLOCK_INDEX, $urandom);
      idle_on = 1'b1;
   endtask

   task automatic test_random_blocks();
      int sent;
      int count;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            7: send_word(OP_LOAD_CHAIN, INDEX_WIDTH'($urandom_range(HASH_WORDS, 15)),
                         random_word());
            8: begin
               send_word(1'($urandom_range(0, 1)), INDEX_WIDTH'($urandom_range(0, 14)),
                         random_word());
               sent++;
            end
            default: begin
               idle_on = ($urandom_range(0, 4) != 0);
               count   = $urandom_range(0, 3);
               repeat (count) begin
                  send_word(OP_LOAD_CHAIN, INDEX_WIDTH'($urandom_range(0, HASH_WORDS - 1)),
                            random_word());
               end
               sent += count;
               count = $urandom_range(0, 15);
               repeat (count) begin
                  send_word(OP_WRITE_BLOCK, INDEX_WIDTH'($urandom_range(0, 14)),
                            random_word());
               end
               send_word(OP_WRITE_BLOCK, LAST_BLOCK_INDEX, random_word());
               sent += count + 1;
               idle_on = 1'b1;
            end
         endcase
      end
   endtask

   initial begin
      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.operation  = OP_LOAD_CHAIN;
      req_if.word_index = '0;
      req_if.word_value = '0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      test_chain_load();
      test_abc_block();
      test_back_pressure();
      test_random_blocks();

      req_if.valid = 1'b0;
      while (expected_hashes.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("** sha256_block_compress: PASSED **");
      end else begin
         $display("** sha256_block_compress: FAILED **");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("%0t: timeout with %0d results outstanding", $time, expected_hashes.size());
      $display("** sha256_block_compress: FAILED **");
      $finish;
   end

endmodule
